>>> rtl/escape_time_fractal_pixel_assert.svh
// Assertion macros shared by the escape-time fractal pixel engine.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ETFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape_time_fractal_pixel: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ETFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape_time_fractal_pixel: assertion failed");

`endif

>>> rtl/etfp_pkg.sv
// Shared types, constants and saturation helper of the fractal pixel engine.
package etfp_pkg;

   // Field and arithmetic widths.
   localparam int COORD_W   = 10;
   localparam int FIX_W     = 32;
   localparam int FRAC_W    = 28;
   localparam int MAP_SHIFT = 30;
   localparam int DVD_W     = COORD_W + MAP_SHIFT;
   localparam int ITER_W    = 11;
   localparam int IDX_W     = 10;
   localparam int ZOOM_W    = 31;
   localparam int WIDE_W    = 40;
   localparam int PROD_W    = 64;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_RE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_IM   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_RE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_IM   = 3'd6;
   localparam logic [ITER_W-1:0]    RST_MAX_ITER   = 11'd42;
   localparam logic [ZOOM_W-1:0]    RST_ZOOM       = 31'h1000_0000;

   // Iteration cap and fixed-point bounds.
   localparam logic [ITER_W-1:0]           ITER_CAP     = 11'd1024;
   localparam logic signed [FIX_W-1:0]     FIX_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [FIX_W-1:0]     FIX_MIN      = 32'sh8000_0000;
   localparam logic signed [WIDE_W-1:0]    WIDE_FIX_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0]    WIDE_FIX_MIN = 40'shFF_8000_0000;
   localparam logic [FIX_W:0]              ESC_BOUND    = 33'h0_4000_0000;
   localparam logic [FIX_W-1:0]            ORIGIN_OFS   = 32'h2000_0000;
   localparam logic [DVD_W-1:0]            BASE_SAT_Q   = 40'h00_A000_0000;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic                     julia_mode;
      logic [ITER_W-1:0]        max_iter;
      logic [ZOOM_W-1:0]        zoom;
      logic signed [FIX_W-1:0]  shift_re;
      logic signed [FIX_W-1:0]  shift_im;
      logic signed [FIX_W-1:0]  julia_re;
      logic signed [FIX_W-1:0]  julia_im;
   } cfg_type;

   // One mapped pixel ready for iteration.
   typedef struct packed {
      logic [COORD_W-1:0]       px;
      logic [COORD_W-1:0]       py;
      logic signed [FIX_W-1:0]  z_re;
      logic signed [FIX_W-1:0]  z_im;
      logic signed [FIX_W-1:0]  c_re;
      logic signed [FIX_W-1:0]  c_im;
   } item_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_FIX_MAX) begin
         return FIX_MAX;
      end else if (v < WIDE_FIX_MIN) begin
         return FIX_MIN;
      end
      return $signed(v[FIX_W-1:0]);
   endfunction

endpackage

>>> rtl/etfp_front.sv
// Front part: accepts a pixel and maps it to its start point and constant.
module etfp_front #(
   parameter int IMG_WIDTH  = 1024,
   parameter int IMG_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  etfp_pkg::cfg_type                   cfg,
   input  logic                                push,
   input  logic [etfp_pkg::COORD_W-1:0]        px,
   input  logic [etfp_pkg::COORD_W-1:0]        py,
   output logic                                full,
   output logic                                out_valid,
   output etfp_pkg::item_type                  out_item,
   input  logic                                out_ready
);

   // The quotient coord*2^30/size splits into coord*floor(2^30/size) plus
   // floor(coord*(2^30 mod size)/size); the second part is taken by a reciprocal
   // multiplication that is exact for every product below 2^T_W. Image sizes are
   // at least 16, which bounds the reciprocal width.
   localparam int SIZE_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
   localparam int REM_W    = $clog2(SIZE_MAX);
   localparam int T_W      = etfp_pkg::COORD_W + REM_W;
   localparam int RCP_K    = T_W + REM_W;
   localparam int RCP_W    = RCP_K - 3;
   localparam int RP_W     = T_W + RCP_W;
   localparam logic [63:0] SPAN    = 64'd1 << etfp_pkg::MAP_SHIFT;
   localparam logic [63:0] RCP_ONE = 64'd1 << RCP_K;
   localparam logic [etfp_pkg::MAP_SHIFT-1:0] QS_X =
      etfp_pkg::MAP_SHIFT'(SPAN / 64'(IMG_WIDTH));
   localparam logic [etfp_pkg::MAP_SHIFT-1:0] QS_Y =
      etfp_pkg::MAP_SHIFT'(SPAN / 64'(IMG_HEIGHT));
   localparam logic [REM_W-1:0] RS_X = REM_W'(SPAN % 64'(IMG_WIDTH));
   localparam logic [REM_W-1:0] RS_Y = REM_W'(SPAN % 64'(IMG_HEIGHT));
   localparam logic [RCP_W-1:0] M_X  =
      RCP_W'((RCP_ONE + 64'(IMG_WIDTH) - 64'd1) / 64'(IMG_WIDTH));
   localparam logic [RCP_W-1:0] M_Y  =
      RCP_W'((RCP_ONE + 64'(IMG_HEIGHT) - 64'd1) / 64'(IMG_HEIGHT));

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCALE = 3'd1;
   localparam logic [2:0] S_RCP   = 3'd2;
   localparam logic [2:0] S_BASE  = 3'd3;
   localparam logic [2:0] S_MULX  = 3'd4;
   localparam logic [2:0] S_MULY  = 3'd5;
   localparam logic [2:0] S_SUMY  = 3'd6;
   localparam logic [2:0] S_PUSH  = 3'd7;

   logic [2:0]                          state_ff, state_in;
   logic [etfp_pkg::COORD_W-1:0]        px_ff, px_in, py_ff, py_in;
   logic [etfp_pkg::DVD_W-1:0]          hx_ff, hx_in, hy_ff, hy_in;
   logic [T_W-1:0]                      tx_ff, tx_in, ty_ff, ty_in;
   logic [etfp_pkg::DVD_W-1:0]          qx_ff, qx_in, qy_ff, qy_in;
   logic signed [etfp_pkg::FIX_W-1:0]   base_re_ff, base_re_in, base_im_ff, base_im_in;
   logic signed [etfp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [etfp_pkg::FIX_W-1:0]   z_re_ff, z_re_in, z_im_ff, z_im_in;

   logic [RP_W-1:0]                     rcp_x, rcp_y;
   logic signed [etfp_pkg::FIX_W-1:0]   mul_a;
   logic signed [etfp_pkg::PROD_W-1:0]  prod_c;
   logic signed [etfp_pkg::PROD_W-1:0]  prod_shr;
   logic signed [etfp_pkg::FIX_W-1:0]   scaled;
   logic signed [etfp_pkg::FIX_W-1:0]   shift_sel;
   logic signed [etfp_pkg::FIX_W-1:0]   mapped;

   // Reciprocal products; the quotient sits at bit RCP_K and above.
   assign rcp_x = RP_W'(tx_ff) * RP_W'(M_X);
   assign rcp_y = RP_W'(ty_ff) * RP_W'(M_Y);

   // Shared zoom multiplier, real axis first and imaginary axis next.
   assign mul_a  = (state_ff == S_MULY) ? base_im_ff : base_re_ff;
   assign prod_c = etfp_pkg::PROD_W'(mul_a) *
                   etfp_pkg::PROD_W'($signed({1'b0, cfg.zoom}));

   // Floor by 2^28, clamp, add the view offset and clamp again.
   assign prod_shr  = prod_ff >>> etfp_pkg::FRAC_W;
   assign scaled    = etfp_pkg::sat_fix($signed(prod_shr[etfp_pkg::WIDE_W-1:0]));
   assign shift_sel = (state_ff == S_MULY) ? cfg.shift_re : cfg.shift_im;
   assign mapped    = etfp_pkg::sat_fix(etfp_pkg::WIDE_W'(scaled) +
                                        etfp_pkg::WIDE_W'(shift_sel));

   // Sequencer and datapath next values.
   always_comb begin
      state_in   = state_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      hx_in      = hx_ff;
      hy_in      = hy_ff;
      tx_in      = tx_ff;
      ty_in      = ty_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      base_re_in = base_re_ff;
      base_im_in = base_im_ff;
      prod_in    = prod_ff;
      z_re_in    = z_re_ff;
      z_im_in    = z_im_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (push) begin
               px_in    = px;
               py_in    = py;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            hx_in    = etfp_pkg::DVD_W'(px_ff) * etfp_pkg::DVD_W'(QS_X);
            hy_in    = etfp_pkg::DVD_W'(py_ff) * etfp_pkg::DVD_W'(QS_Y);
            tx_in    = T_W'(px_ff) * T_W'(RS_X);
            ty_in    = T_W'(py_ff) * T_W'(RS_Y);
            state_in = S_RCP;
         end
         S_RCP: begin
            qx_in    = hx_ff + etfp_pkg::DVD_W'(rcp_x[RP_W-1:RCP_K]);
            qy_in    = hy_ff + etfp_pkg::DVD_W'(rcp_y[RP_W-1:RCP_K]);
            state_in = S_BASE;
         end
         S_BASE: begin
            // Subtract 2.0 and clamp; the quotient is never negative.
            base_re_in = (qx_ff >= etfp_pkg::BASE_SAT_Q) ? etfp_pkg::FIX_MAX :
                         $signed(qx_ff[etfp_pkg::FIX_W-1:0] - etfp_pkg::ORIGIN_OFS);
            base_im_in = (qy_ff >= etfp_pkg::BASE_SAT_Q) ? etfp_pkg::FIX_MAX :
                         $signed(qy_ff[etfp_pkg::FIX_W-1:0] - etfp_pkg::ORIGIN_OFS);
            state_in   = S_MULX;
         end
         S_MULX: begin
            prod_in  = prod_c;
            state_in = S_MULY;
         end
         S_MULY: begin
            z_re_in  = mapped;
            prod_in  = prod_c;
            state_in = S_SUMY;
         end
         S_SUMY: begin
            z_im_in  = mapped;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      py_ff      <= py_in;
      hx_ff      <= hx_in;
      hy_ff      <= hy_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      base_re_ff <= base_re_in;
      base_im_ff <= base_im_in;
      prod_ff    <= prod_in;
      z_re_ff    <= z_re_in;
      z_im_ff    <= z_im_in;
   end

   // Mapped word toward the queue; the constant follows the mode bit.
   assign full           = (state_ff != S_IDLE);
   assign out_valid      = (state_ff == S_PUSH);
   assign out_item.px    = px_ff;
   assign out_item.py    = py_ff;
   assign out_item.z_re  = z_re_ff;
   assign out_item.z_im  = z_im_ff;
   assign out_item.c_re  = cfg.julia_mode ? cfg.julia_re : z_re_ff;
   assign out_item.c_im  = cfg.julia_mode ? cfg.julia_im : z_im_ff;

endmodule

>>> rtl/etfp_queue.sv
// Short queue of mapped pixels between the front and back parts.
module etfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  etfp_pkg::item_type  wr_item,
   output logic                full,
   input  logic                rd_en,
   output etfp_pkg::item_type  rd_item,
   output logic                empty
);

   etfp_pkg::item_type                entry_ff [etfp_pkg::QUEUE_DEPTH];
   logic [etfp_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [etfp_pkg::QCNT_W-1:0]       count_ff;
   logic                              do_wr, do_rd;

   assign full    = (count_ff == etfp_pkg::QCNT_W'(etfp_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_item = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> rtl/etfp_back.sv
// Back part: iterates z = z*z + c for one pixel and holds the result word.
module etfp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  etfp_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   input  etfp_pkg::item_type                  in_item,
   output logic                                in_pop,
   output logic                                empty,
   input  logic                                pop,
   output logic [etfp_pkg::COORD_W-1:0]        rsp_out_px,
   output logic [etfp_pkg::COORD_W-1:0]        rsp_out_py,
   output logic [etfp_pkg::IDX_W-1:0]          rsp_escape_index,
   output logic                                rsp_inside_res
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [etfp_pkg::COORD_W-1:0]        px_ff, px_in, py_ff, py_in;
   logic signed [etfp_pkg::FIX_W-1:0]   c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [etfp_pkg::FIX_W-1:0]   re_ff, re_in, im_ff, im_in;
   logic signed [etfp_pkg::FIX_W-1:0]   sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic signed [etfp_pkg::FIX_W-1:0]   nre_ff, nre_in;
   logic signed [etfp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [etfp_pkg::ITER_W-1:0]         iter_ff, iter_in;
   logic                                check_ff, check_in;
   logic                                esc_ff, esc_in;
   logic [etfp_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                                out_valid_ff, out_valid_in;
   logic [etfp_pkg::COORD_W-1:0]        out_px_ff, out_py_ff;
   logic [etfp_pkg::IDX_W-1:0]          out_idx_ff;
   logic                                out_inside_ff;

   logic [etfp_pkg::ITER_W-1:0]         limit;
   logic signed [etfp_pkg::FIX_W-1:0]   mul_a_op;
   logic signed [etfp_pkg::PROD_W-1:0]  mul_a, mul_b;
   logic signed [etfp_pkg::PROD_W-1:0]  sh_a, sh_b, sh_p;
   logic [etfp_pkg::FIX_W:0]            mag;
   logic [etfp_pkg::ITER_W-1:0]         iter_last;
   logic                                out_free;

   assign limit = (cfg.max_iter > etfp_pkg::ITER_CAP) ? etfp_pkg::ITER_CAP : cfg.max_iter;

   // Multiplier A forms re*re while squaring and re*im otherwise; B forms im*im.
   assign mul_a_op = (state_ff == S_SQ) ? re_ff : im_ff;
   assign mul_a    = etfp_pkg::PROD_W'(re_ff) * etfp_pkg::PROD_W'(mul_a_op);
   assign mul_b    = etfp_pkg::PROD_W'(im_ff) * etfp_pkg::PROD_W'(im_ff);
   assign sh_a     = mul_a >>> etfp_pkg::FRAC_W;
   assign sh_b     = mul_b >>> etfp_pkg::FRAC_W;
   assign sh_p     = prod_ff >>> (etfp_pkg::FRAC_W - 1);

   // Squares are never negative, so the magnitude is an unsigned sum.
   assign mag       = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign iter_last = iter_ff - 1'b1;
   assign out_free  = !out_valid_ff || pop;

   // Iteration sequencer: square, test and multiply, then add.
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      sq_re_in     = sq_re_ff;
      sq_im_in     = sq_im_ff;
      nre_in       = nre_ff;
      prod_in      = prod_ff;
      iter_in      = iter_ff;
      check_in     = check_ff;
      esc_in       = esc_ff;
      idx_in       = idx_ff;
      in_pop       = 1'b0;
      out_valid_in = out_valid_ff && !pop;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               px_in    = in_item.px;
               py_in    = in_item.py;
               re_in    = in_item.z_re;
               im_in    = in_item.z_im;
               c_re_in  = in_item.c_re;
               c_im_in  = in_item.c_im;
               iter_in  = '0;
               check_in = 1'b0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_re_in = etfp_pkg::sat_fix($signed(sh_a[etfp_pkg::WIDE_W-1:0]));
            sq_im_in = etfp_pkg::sat_fix($signed(sh_b[etfp_pkg::WIDE_W-1:0]));
            state_in = S_MUL;
         end
         S_MUL: begin
            // The squares of the previous step double as the escape test.
            if (check_ff && (mag > etfp_pkg::ESC_BOUND)) begin
               esc_in   = 1'b1;
               idx_in   = iter_last[etfp_pkg::IDX_W-1:0];
               state_in = S_FIN;
            end else if (iter_ff == limit) begin
               esc_in   = 1'b0;
               state_in = S_FIN;
            end else begin
               prod_in  = mul_a;
               nre_in   = etfp_pkg::sat_fix(etfp_pkg::WIDE_W'(sq_re_ff) -
                                            etfp_pkg::WIDE_W'(sq_im_ff) +
                                            etfp_pkg::WIDE_W'(c_re_ff));
               iter_in  = iter_ff + 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            re_in    = nre_ff;
            im_in    = etfp_pkg::sat_fix($signed(sh_p[etfp_pkg::WIDE_W-1:0]) +
                                         etfp_pkg::WIDE_W'(c_im_ff));
            check_in = 1'b1;
            state_in = S_SQ;
         end
         S_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      c_re_ff  <= c_re_in;
      c_im_ff  <= c_im_in;
      re_ff    <= re_in;
      im_ff    <= im_in;
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
      nre_ff   <= nre_in;
      prod_ff  <= prod_in;
      iter_ff  <= iter_in;
      check_ff <= check_in;
      esc_ff   <= esc_in;
      idx_ff   <= idx_in;
   end

   // Result word register, loaded when the sequencer finishes a pixel.
   always_ff @(posedge clock) begin
      if ((state_ff == S_FIN) && out_free) begin
         out_px_ff     <= px_ff;
         out_py_ff     <= py_ff;
         out_idx_ff    <= esc_ff ? idx_ff : '0;
         out_inside_ff <= !esc_ff;
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_out_px       = out_px_ff;
   assign rsp_out_py       = out_py_ff;
   assign rsp_escape_index = out_idx_ff;
   assign rsp_inside_res   = out_inside_ff;

endmodule

>>> rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel engine with its register file.
// Each pixel word (req_px, req_py) yields one result word in arrival order. The front
// part maps a pixel to its complex start point with a constant reciprocal multiplication
// by the image size and a shared zoom multiplier; it takes one pixel at a time and shows
// full until the mapped word enters the queue. The back part runs z = z*z + c with the
// steps square, multiply and add per iteration, plus setup, a final test and hand-off;
// a pixel runs at most min(max_iter, 1024) iterations there. A two-word queue lets
// the front map the next pixels while the back iterates. A finished result waits in an
// output register while the back part starts on the next pixel. Registers are written at
// any edge with csr_we high and should only change while no pixel is in flight.
module escape_time_fractal_pixel #(
   parameter int IMG_WIDTH  = 1024,
   parameter int IMG_HEIGHT = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  logic [etfp_pkg::COORD_W-1:0]           req_px,
   input  logic [etfp_pkg::COORD_W-1:0]           req_py,
   output logic                                   full,
   output logic                                   empty,
   input  logic                                   pop,
   output logic [etfp_pkg::COORD_W-1:0]           rsp_out_px,
   output logic [etfp_pkg::COORD_W-1:0]           rsp_out_py,
   output logic [etfp_pkg::IDX_W-1:0]             rsp_escape_index,
   output logic                                   rsp_inside_res,
   input  logic                                   csr_we,
   input  logic [etfp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [etfp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

`include "escape_time_fractal_pixel_assert.svh"

   etfp_pkg::cfg_type   cfg_ff;
   etfp_pkg::item_type  fe_item, q_item;
   logic                fe_valid, q_full, q_empty, be_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.julia_mode <= 1'b0;
         cfg_ff.max_iter   <= etfp_pkg::RST_MAX_ITER;
         cfg_ff.zoom       <= etfp_pkg::RST_ZOOM;
         cfg_ff.shift_re   <= '0;
         cfg_ff.shift_im   <= '0;
         cfg_ff.julia_re   <= '0;
         cfg_ff.julia_im   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            etfp_pkg::CSR_JULIA_MODE: cfg_ff.julia_mode <= csr_wdata[0];
            etfp_pkg::CSR_MAX_ITER:   cfg_ff.max_iter <= csr_wdata[etfp_pkg::ITER_W-1:0];
            etfp_pkg::CSR_ZOOM:       cfg_ff.zoom <= csr_wdata[etfp_pkg::ZOOM_W-1:0];
            etfp_pkg::CSR_SHIFT_RE:   cfg_ff.shift_re <= $signed(csr_wdata);
            etfp_pkg::CSR_SHIFT_IM:   cfg_ff.shift_im <= $signed(csr_wdata);
            etfp_pkg::CSR_JULIA_RE:   cfg_ff.julia_re <= $signed(csr_wdata);
            etfp_pkg::CSR_JULIA_IM:   cfg_ff.julia_im <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Pixel mapping.
   etfp_front #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .px        (req_px),
      .py        (req_py),
      .full      (full),
      .out_valid (fe_valid),
      .out_item  (fe_item),
      .out_ready (!q_full)
   );

   // Decoupling queue.
   etfp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fe_valid),
      .wr_item (fe_item),
      .full    (q_full),
      .rd_en   (be_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   // Iteration and result register.
   etfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (!q_empty),
      .in_item          (q_item),
      .in_pop           (be_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_px       (rsp_out_px),
      .rsp_out_py       (rsp_out_py),
      .rsp_escape_index (rsp_escape_index),
      .rsp_inside_res   (rsp_inside_res)
   );

   // An inside pixel always reports a zero escape index.
   `ETFP_ASSERT_IMPLY(a_inside_zero_idx, clock, reset, !empty && rsp_inside_res, rsp_escape_index == '0)
   // The front stays busy on the cycle after it takes a pixel.
   `ETFP_ASSERT_NEXT(a_busy_after_accept, clock, reset, push && !full, full)
   // A mapped word stalled by a full queue is held unchanged.
   `ETFP_ASSERT_NEXT(a_front_holds, clock, reset, fe_valid && q_full, fe_valid && $stable(fe_item))
   // The back part only takes words the queue really holds.
   `ETFP_ASSERT_IMPLY(a_pop_nonempty, clock, reset, be_pop, !q_empty)

endmodule
